@@ hdl/tl_length_prefixed_deframer_macros.svh @@
// assertion macros for the length-prefixed deframer
// all of them sample on clk and are disabled while rst_n is low
`ifndef TL_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define TL_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

// same-cycle implication
`define TLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_pkg
// Types and constants shared by the length-prefixed deframer modules.
// ----------------------------------------------------------------------------
package tld_pkg;

    // field geometry
    localparam int LEN_W      = 24;
    localparam int WORD_BYTES = 4;
    localparam int PAD_W      = $clog2(WORD_BYTES);

    // prefix codes
    localparam logic [7:0] SHORT_MAX   = 8'd253;
    localparam logic [7:0] LONG_PREFIX = 8'd254;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_PREFIX    = 2'd1;
    localparam logic [1:0] ERR_TRUNC_LEN = 2'd2;
    localparam logic [1:0] ERR_TRUNC_PAY = 2'd3;

    // decoder phase
    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_PAD     = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    // input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } item_t;

    // output beat
    typedef struct packed {
        logic [1:0]       result_kind;
        logic [7:0]       payload_byte;
        logic             field_last;
        logic [LEN_W-1:0] field_length;
        logic [1:0]       error_code;
    } result_t;

endpackage

@@ hdl/tld_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_in_stage
// Input register: captures one byte beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module tld_in_stage
    import tld_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  logic  take,
    output logic  beat_valid,
    output item_t beat
);

    logic  vld_reg;
    logic  vld_next;
    item_t beat_reg;
    logic  accept;

    // stall only while a held beat cannot move on
    assign item_stall = vld_reg && !take;
    assign accept     = item_valid && !item_stall;
    assign vld_next   = accept ? 1'b1 : (take ? 1'b0 : vld_reg);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // beat data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= item;
        end
    end

    assign beat_valid = vld_reg;
    assign beat       = beat_reg;

endmodule

@@ hdl/tld_core.sv @@
`timescale 1ns / 1ps
`include "tl_length_prefixed_deframer_macros.svh"
// ----------------------------------------------------------------------------
// tld_core
// Header and payload state machine plus the result register. One held byte
// is decoded per cycle whenever the result register can take its result.
// ----------------------------------------------------------------------------
module tld_core
    import tld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    beat_valid,
    input  item_t   beat,
    output logic    take,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       lbs_reg, lbs_next;
    logic [PAD_W-1:0] pad_reg, pad_next;
    logic             out_vld_reg, out_vld_next;
    result_t          res_reg;

    logic             out_free;
    logic             has_res;
    result_t          res;
    logic             hdr_go;
    logic [LEN_W-1:0] hdr_len;
    logic [PAD_W-1:0] hdr_pad;
    logic [LEN_W-1:0] remain_dec;
    logic [LEN_W-1:0] long_len;
    logic [7:0]       b;
    logic             last_in_buf;

    assign b           = beat.in_byte;
    assign last_in_buf = beat.buffer_end;
    assign out_free    = !out_vld_reg || !result_stall;
    assign take        = beat_valid && out_free;
    assign remain_dec  = remain_reg - LEN_W'(1);
    assign long_len    = {b, len_reg[15:0]};

    // decode step for the held byte
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        len_next    = len_reg;
        lbs_next    = lbs_reg;
        pad_next    = pad_reg;
        has_res     = 1'b0;
        res         = '0;
        hdr_go      = 1'b0;
        hdr_len     = '0;
        hdr_pad     = '0;

        unique case (phase_reg)
            PH_LENGTH:
            begin
                lbs_next = lbs_reg + 2'd1;
                unique case (lbs_reg)
                    2'd0:    len_next[7:0]   = b;
                    2'd1:    len_next[15:8]  = b;
                    default: len_next[23:16] = b;
                endcase
                if (lbs_reg == 2'd2)
                begin
                    lbs_next = 2'd0;
                    hdr_go   = 1'b1;
                    hdr_len  = long_len;
                    hdr_pad  = PAD_W'(0) - long_len[PAD_W-1:0];
                end
                else if (last_in_buf)
                begin
                    lbs_next         = 2'd0;
                    phase_next       = PH_PREFIX;
                    has_res          = 1'b1;
                    res.result_kind  = KIND_ERROR;
                    res.error_code   = ERR_TRUNC_LEN;
                end
            end
            PH_PAYLOAD:
            begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    has_res          = 1'b1;
                    res.result_kind  = KIND_PAYLOAD;
                    res.payload_byte = b;
                    res.field_last   = 1'b1;
                    res.field_length = len_reg;
                    phase_next = (pad_reg != '0 && !last_in_buf) ? PH_PAD : PH_PREFIX;
                    if (last_in_buf)
                    begin
                        pad_next = '0;
                    end
                end
                else if (last_in_buf)
                begin
                    remain_next      = '0;
                    phase_next       = PH_PREFIX;
                    has_res          = 1'b1;
                    res.result_kind  = KIND_ERROR;
                    res.field_length = len_reg;
                    res.error_code   = ERR_TRUNC_PAY;
                end
                else
                begin
                    has_res          = 1'b1;
                    res.result_kind  = KIND_PAYLOAD;
                    res.payload_byte = b;
                    res.field_length = len_reg;
                end
            end
            PH_PAD:
            begin
                pad_next = pad_reg - PAD_W'(1);
                if (pad_next == '0 || last_in_buf)
                begin
                    pad_next   = '0;
                    phase_next = PH_PREFIX;
                end
            end
            PH_DISCARD:
            begin
                if (last_in_buf)
                begin
                    phase_next = PH_PREFIX;
                end
            end
            default:
            begin
                len_next    = '0;
                lbs_next    = 2'd0;
                remain_next = '0;
                pad_next    = '0;
                if (b <= SHORT_MAX)
                begin
                    hdr_go  = 1'b1;
                    hdr_len = LEN_W'(b);
                    hdr_pad = PAD_W'(WORD_BYTES - 1) - b[PAD_W-1:0];
                end
                else if (b == LONG_PREFIX)
                begin
                    if (last_in_buf)
                    begin
                        phase_next      = PH_PREFIX;
                        has_res         = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_TRUNC_LEN;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                else
                begin
                    phase_next      = last_in_buf ? PH_PREFIX : PH_DISCARD;
                    has_res         = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_PREFIX;
                end
            end
        endcase

        // header complete: empty field, truncation or start of payload
        if (hdr_go)
        begin
            len_next = hdr_len;
            pad_next = hdr_pad;
            if (hdr_len == '0)
            begin
                phase_next = (hdr_pad != '0 && !last_in_buf) ? PH_PAD : PH_PREFIX;
                if (last_in_buf)
                begin
                    pad_next = '0;
                end
                has_res         = 1'b1;
                res.result_kind = KIND_EMPTY;
                res.field_last  = 1'b1;
            end
            else if (last_in_buf)
            begin
                phase_next       = PH_PREFIX;
                has_res          = 1'b1;
                res.result_kind  = KIND_ERROR;
                res.field_length = hdr_len;
                res.error_code   = ERR_TRUNC_PAY;
            end
            else
            begin
                remain_next = hdr_len;
                phase_next  = PH_PAYLOAD;
            end
        end
    end

    // result valid follows the slot: load on a take with a result, clear on drain
    always_comb
    begin
        if (out_free)
        begin
            out_vld_next = take && has_res;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            remain_reg  <= '0;
            len_reg     <= '0;
            lbs_reg     <= 2'd0;
            pad_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                remain_reg <= remain_next;
                len_reg    <= len_next;
                lbs_reg    <= lbs_next;
                pad_reg    <= pad_next;
            end
        end
    end

    // result data
    always_ff @(posedge clk)
    begin
        if (take && has_res)
        begin
            res_reg <= res;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = res_reg;

    // checks
    `TLD_ASSERT_IMP(a_payload_count, phase_reg == PH_PAYLOAD,
        remain_reg != '0 && remain_reg <= len_reg, "payload count out of range")
    `TLD_ASSERT_IMP(a_pad_nonzero, phase_reg == PH_PAD, pad_reg != '0,
        "padding phase with no padding left")
    `TLD_ASSERT_IMP(a_length_count, phase_reg == PH_LENGTH, lbs_reg != 2'd3,
        "long length byte count overflow")
    `TLD_ASSERT_NXT(a_buffer_restart, take && last_in_buf, phase_reg == PH_PREFIX,
        "decoder not at prefix after buffer end")
    `TLD_ASSERT_IMP(a_code_only_on_error,
        out_vld_reg && res_reg.result_kind != KIND_ERROR,
        res_reg.error_code == ERR_NONE, "error code on a non-error result")

endmodule

@@ hdl/tl_length_prefixed_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tl_length_prefixed_deframer
// Splits a byte stream into length-prefixed TL byte-string fields.
// ----------------------------------------------------------------------------
// The deframer takes one message byte per beat and sustains one beat per
// cycle while the output side does not stall. A byte passes the input
// register, is decoded by the header/payload state machine and then lands in
// the result register. Each byte gives at most one result (payload byte,
// empty field or error). Padding and discarded bytes give none; a header
// byte gives one only for an empty field or an error. The input stalls only
// while the result register is full and the output side stalls it. The input
// and result registers hold one beat each and are the only buffering between
// the two sides. Payload bytes already delivered for a field that later
// reports a truncated-payload error are to be dropped.
module tl_length_prefixed_deframer
    import tld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic  take;
    logic  beat_valid;
    item_t beat;

    // input register
    tld_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // decoder and result register
    tld_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat_valid   (beat_valid),
        .beat         (beat),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
